// ----- rtl/gvs_pkg.sv -----
// Shared widths, body entry type and register index codes for the
// gravity Verlet step block. No dependencies.
package gvs_pkg;

  localparam int POS_W    = 24;  // signed Q16.8 position
  localparam int MASS_W   = 18;
  localparam int DIFF_W   = 25;  // body minus particle, and its magnitude
  localparam int SQ_W     = 49;  // one squared magnitude
  localparam int DSQ_W    = 50;  // squared distance
  localparam int PROD_W   = 43;  // mass times magnitude
  localparam int TERM_W   = 47;  // term saturates at all ones
  localparam int ACC_W    = 52;  // signed sum of terms
  localparam int MAG_W    = 51;  // magnitude of the sum
  localparam int GAIN_W   = 32;
  localparam int MSQ_W    = 16;
  localparam int ACT_W    = 4;
  localparam int PMUL_W   = 83;  // magnitude times gain
  localparam int DELTA_W  = 27;  // delta magnitude, capped at 2^26
  localparam int NEXT_W   = 30;  // unsaturated next position

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SQ = 2'd2;

  localparam logic MODE_LOAD = 1'b0;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [MASS_W-1:0]       w;
  } body_t;

endpackage

// ----- rtl/gvs_cell.sv -----
// One cell of the body ring: holds one attractor entry, loads it from the
// input side and passes it to its neighbor on a rotate. Uses gvs_pkg.
module gvs_cell (
  input  logic          clk,
  input  logic          load,
  input  gvs_pkg::body_t load_body,
  input  logic          shift,
  input  gvs_pkg::body_t shift_in,
  output gvs_pkg::body_t body
);
  import gvs_pkg::*;

  body_t held;

  // load wins over rotate; they never meet in practice
  always_ff @(posedge clk) begin
    if (load) begin
      held <= load_body;
    end else if (shift) begin
      held <= shift_in;
    end
  end

  assign body = held;

endmodule

// ----- rtl/gvs_sqrt.sv -----
// Bit-pair serial integer square root, one result bit per cycle.
// Stand-alone, no package needed.
module gvs_sqrt #(
  parameter int IN_W = 50
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [IN_W-1:0]   value,
  output logic              done,
  output logic [IN_W/2-1:0] root
);
  localparam int RT_W  = IN_W / 2;
  localparam int RM_W  = RT_W + 2;
  localparam int CNT_W = $clog2(RT_W + 1);

  logic [IN_W-1:0]  val;
  logic [RM_W-1:0]  rem;
  logic [RT_W-1:0]  res;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [RM_W-1:0]  shifted;
  logic [RM_W-1:0]  trial;
  logic             ge;

  assign shifted = {rem[RM_W-3:0], val[IN_W-1:IN_W-2]};
  assign trial   = {res, 2'b01};
  assign ge      = shifted >= trial;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(RT_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: bring down two bits, try the next root bit
  always_ff @(posedge clk) begin
    if (start) begin
      val <= value;
      rem <= '0;
      res <= '0;
    end else if (busy) begin
      val <= {val[IN_W-3:0], 2'b00};
      rem <= ge ? shifted - trial : shifted;
      res <= {res[RT_W-2:0], ge};
    end
  end

  assign root = res;

endmodule

// ----- rtl/gvs_div.sv -----
// Restoring serial divider, one quotient bit per cycle, full-width
// quotient. Stand-alone, no package needed.
module gvs_div #(
  parameter int NUM_W = 63,
  parameter int DEN_W = 50
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dv;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   t;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign t    = {rem, q[NUM_W-1]};
  assign diff = t - {1'b0, dv};
  assign ge   = t >= {1'b0, dv};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift the dividend out and the quotient in
  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num;
      rem <= '0;
      dv  <= den;
    end else if (busy) begin
      rem <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
      q   <= {q[NUM_W-2:0], ge};
    end
  end

  assign quo = q;

endmodule

// ----- rtl/gravity_verlet_step.sv -----
// Top level of the gravity Verlet step: body ring, shared root and
// divider units, gain and output stage. Uses gvs_pkg, gvs_cell,
// gvs_sqrt, gvs_div.
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+----------------------
//  s_axis   | in        | s_axis_tvalid/s_axis_tready  | tuser mode, tdata fields
//  m_axis   | out       | m_axis_tvalid/m_axis_tready  | tdata next and prior
//  cfg      | in        | cfg_valid/cfg_ready          | cfg_index, cfg_data
//
// A step item rotates the body ring once per slot. A slot that is skipped
// passes straight on; a body that contributes goes through the serial
// root and the two serial divisions. The S_MAG, S_MUL, S_ADD and S_FIN
// states finish it.
// Reset clears control and the configuration registers; body entries and datapath registers hold no reset.
// The result waits in the output register; a new item is taken meanwhile.
module gravity_verlet_step #(
  parameter int MAX_BODIES    = 8,
  parameter int POS_FRAC_BITS = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // body_index, body_x, body_y, body_mass, particle_x, particle_y,
  // particle_old_x, particle_old_y, zero fill
  input  logic [167:0] s_axis_tdata,
  // mode
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // next_x, next_y, prior_x, prior_y
  output logic [95:0]  m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [gvs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]  cfg_data
);
  import gvs_pkg::*;

  localparam int CW     = $clog2(MAX_BODIES + 1);
  localparam int FR2    = 2 * POS_FRAC_BITS;
  localparam int DIV_NW = (PROD_W + 16 > TERM_W + FR2) ? PROD_W + 16 : TERM_W + FR2;
  localparam int OS     = 40 - POS_FRAC_BITS;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_DIFF = 13'b0000000000010,
    S_SQ   = 13'b0000000000100,
    S_DSQ  = 13'b0000000001000,
    S_CHK  = 13'b0000000010000,
    S_ROOT = 13'b0000000100000,
    S_DIV1 = 13'b0000001000000,
    S_DIV2 = 13'b0000010000000,
    S_NEXT = 13'b0000100000000,
    S_MAG  = 13'b0001000000000,
    S_MUL  = 13'b0010000000000,
    S_ADD  = 13'b0100000000000,
    S_FIN  = 13'b1000000000000
  } state_t;

  function automatic logic [TERM_W-1:0] sat_term(input logic [DIV_NW-1:0] q);
    if (|q[DIV_NW-1:TERM_W]) begin
      return '1;
    end
    return q[TERM_W-1:0];
  endfunction

  function automatic logic signed [DELTA_W:0] gain_delta(
    input logic [PMUL_W-1:0] p, input logic neg);
    logic [PMUL_W-1:0]  r;
    logic [DELTA_W-1:0] d;
    logic signed [DELTA_W:0] sd;
    r = p >> OS;
    if (r > PMUL_W'(1) << 26) begin
      d = DELTA_W'(1) << 26;
    end else begin
      d = r[DELTA_W-1:0];
    end
    sd = signed'({1'b0, d});
    return neg ? -sd : sd;
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(
    input logic signed [NEXT_W-1:0] v);
    if (v > NEXT_W'(8388607)) begin
      return 24'sh7FFFFF;
    end else if (v < -NEXT_W'(8388608)) begin
      return 24'sh800000;
    end
    return v[POS_W-1:0];
  endfunction

  // configuration registers
  logic [ACT_W-1:0]  active_bodies;
  logic [GAIN_W-1:0] step_gain;
  logic [MSQ_W-1:0]  min_sq_distance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_bodies   <= '0;
      step_gain       <= 32'd16777216;
      min_sq_distance <= 16'd25;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ACTIVE: active_bodies   <= cfg_data[ACT_W-1:0];
        CFG_GAIN:   step_gain       <= cfg_data;
        CFG_MIN_SQ: min_sq_distance <= cfg_data[MSQ_W-1:0];
        default:    ;
      endcase
    end
  end

  // input fields
  logic                    in_mode;
  logic [2:0]              in_index;
  body_t                   in_body;
  logic signed [POS_W-1:0] in_px, in_py, in_ox, in_oy;

  assign in_mode   = s_axis_tuser;
  assign in_index  = s_axis_tdata[2:0];
  assign in_body.x = s_axis_tdata[26:3];
  assign in_body.y = s_axis_tdata[50:27];
  assign in_body.w = s_axis_tdata[68:51];
  assign in_px     = s_axis_tdata[92:69];
  assign in_py     = s_axis_tdata[116:93];
  assign in_ox     = s_axis_tdata[140:117];
  assign in_oy     = s_axis_tdata[164:141];

  state_t state;
  logic   in_fire;
  logic   rot;

  assign s_axis_tready = (state == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign rot           = (state == S_NEXT);

  // body ring, head at cell 0
  body_t cell_out [MAX_BODIES];

  for (genvar i = 0; i < MAX_BODIES; i++) begin : g_cell
    gvs_cell u_cell (
      .clk       (clk),
      .load      (in_fire && in_mode == MODE_LOAD && int'(in_index) == i),
      .load_body (in_body),
      .shift     (rot),
      .shift_in  (cell_out[(i + 1) % MAX_BODIES]),
      .body      (cell_out[i])
    );
  end

  // clamp the body count, scale the threshold
  logic [CW-1:0]    count;
  logic [DSQ_W-1:0] limit;

  always_comb begin
    if (int'(active_bodies) > MAX_BODIES) begin
      count = CW'(MAX_BODIES);
    end else begin
      count = CW'(active_bodies);
    end
  end

  assign limit = {{(DSQ_W-MSQ_W){1'b0}}, min_sq_distance} << FR2;

  // per-step registers
  logic signed [POS_W-1:0] px, py, ox, oy;
  logic [CW-1:0]           k;
  logic [DIFF_W-1:0]       adx, ady;
  logic                    sx, sy;
  logic [MASS_W-1:0]       wt;
  logic [SQ_W-1:0]         sqx, sqy;
  logic [PROD_W-1:0]       mx, my;
  logic [DSQ_W-1:0]        dsq;
  logic signed [ACC_W-1:0] acc_x, acc_y;
  logic [MAG_W-1:0]        mag_x, mag_y;
  logic                    neg_x, neg_y;
  logic [63:0]             plo_x, plo_y;
  logic [MAG_W-1:0]        phi_x, phi_y;
  logic [PMUL_W-1:0]       prod_x, prod_y;
  logic                    out_valid;
  logic [95:0]             out_data;

  // differences against the head body
  logic signed [DIFF_W-1:0] dx, dy;
  assign dx = DIFF_W'(cell_out[0].x) - DIFF_W'(px);
  assign dy = DIFF_W'(cell_out[0].y) - DIFF_W'(py);

  // shared units
  logic                    sqrt_start, sqrt_done;
  logic [DIFF_W-1:0]       root;
  logic                    div_start, div_done, div_done_y;
  logic [DIV_NW-1:0]       num_x, num_y, quo_x, quo_y;
  logic [DSQ_W-1:0]        den;
  logic [TERM_W-1:0]       term_x, term_y;

  assign sqrt_start = (state == S_CHK) && (k < count) && (dsq > limit);
  assign div_start  = (state == S_ROOT && sqrt_done) || (state == S_DIV1 && div_done);
  assign term_x     = sat_term(quo_x);
  assign term_y     = sat_term(quo_y);

  always_comb begin
    if (state == S_ROOT) begin
      num_x = DIV_NW'(mx) << 16;
      num_y = DIV_NW'(my) << 16;
      den   = DSQ_W'(root);
    end else begin
      num_x = DIV_NW'(term_x) << FR2;
      num_y = DIV_NW'(term_y) << FR2;
      den   = dsq;
    end
  end

  gvs_sqrt #(.IN_W(DSQ_W)) u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .value (dsq),
    .done  (sqrt_done),
    .root  (root)
  );

  gvs_div #(.NUM_W(DIV_NW), .DEN_W(DSQ_W)) u_div_x (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_x),
    .den   (den),
    .done  (div_done),
    .quo   (quo_x)
  );

  gvs_div #(.NUM_W(DIV_NW), .DEN_W(DSQ_W)) u_div_y (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_y),
    .den   (den),
    .done  (div_done_y),
    .quo   (quo_y)
  );

  // final position arithmetic
  logic signed [DELTA_W:0]  dlt_x, dlt_y;
  logic signed [NEXT_W-1:0] sum_x, sum_y;
  logic                     out_free;

  assign dlt_x    = gain_delta(prod_x, neg_x);
  assign dlt_y    = gain_delta(prod_y, neg_y);
  assign sum_x    = (NEXT_W'(px) <<< 1) - NEXT_W'(ox) + NEXT_W'(dlt_x);
  assign sum_y    = (NEXT_W'(py) <<< 1) - NEXT_W'(oy) + NEXT_W'(dlt_y);
  assign out_free = !out_valid || m_axis_tready;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      // load a new result when the register frees, drop a taken one
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire && in_mode != MODE_LOAD) begin
            k     <= '0;
            state <= S_DIFF;
          end
        end
        S_DIFF: state <= S_SQ;
        S_SQ:   state <= S_DSQ;
        S_DSQ:  state <= S_CHK;
        S_CHK:  state <= sqrt_start ? S_ROOT : S_NEXT;
        S_ROOT: if (sqrt_done) begin
          state <= S_DIV1;
        end
        S_DIV1: if (div_done) begin
          state <= S_DIV2;
        end
        S_DIV2: if (div_done) begin
          state <= S_NEXT;
        end
        S_NEXT: begin
          k <= k + 1'b1;
          if (k == CW'(MAX_BODIES - 1)) begin
            state <= S_MAG;
          end else begin
            state <= S_DIFF;
          end
        end
        S_MAG: state <= S_MUL;
        S_MUL: state <= S_ADD;
        S_ADD: state <= S_FIN;
        S_FIN: if (out_free) begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire && in_mode != MODE_LOAD) begin
      px    <= in_px;
      py    <= in_py;
      ox    <= in_ox;
      oy    <= in_oy;
      acc_x <= '0;
      acc_y <= '0;
    end
    if (state == S_DIFF) begin
      adx <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
      ady <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
      sx  <= dx[DIFF_W-1];
      sy  <= dy[DIFF_W-1];
      wt  <= cell_out[0].w;
    end
    if (state == S_SQ) begin
      sqx <= SQ_W'(adx * adx);
      sqy <= SQ_W'(ady * ady);
      mx  <= PROD_W'(wt * adx);
      my  <= PROD_W'(wt * ady);
    end
    if (state == S_DSQ) begin
      dsq <= {1'b0, sqx} + {1'b0, sqy};
    end
    if (state == S_DIV2 && div_done) begin
      acc_x <= sx ? acc_x - ACC_W'(term_x) : acc_x + ACC_W'(term_x);
      acc_y <= sy ? acc_y - ACC_W'(term_y) : acc_y + ACC_W'(term_y);
    end
    if (state == S_MAG) begin
      mag_x <= acc_x[ACC_W-1] ? MAG_W'(-acc_x) : MAG_W'(acc_x);
      mag_y <= acc_y[ACC_W-1] ? MAG_W'(-acc_y) : MAG_W'(acc_y);
      neg_x <= acc_x[ACC_W-1];
      neg_y <= acc_y[ACC_W-1];
    end
    if (state == S_MUL) begin
      plo_x <= mag_x[31:0] * step_gain;
      plo_y <= mag_y[31:0] * step_gain;
      phi_x <= MAG_W'(mag_x[MAG_W-1:32] * step_gain);
      phi_y <= MAG_W'(mag_y[MAG_W-1:32] * step_gain);
    end
    if (state == S_ADD) begin
      prod_x <= {phi_x, 32'b0} + PMUL_W'(plo_x);
      prod_y <= {phi_y, 32'b0} + PMUL_W'(plo_y);
    end
    if (state == S_FIN && out_free) begin
      out_data <= {py, px, sat_pos(sum_y), sat_pos(sum_x)};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

// ----- sim/gravity_verlet_step_tb.sv -----
// Self-checking testbench for gravity_verlet_step: body loads, particle steps
// and register writes, checked against an in-bench integer model of the block.
// Depends on rtl/gvs_pkg.sv and rtl/gravity_verlet_step.sv.
module gravity_verlet_step_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gvs_pkg::*;

  localparam int BODIES     = 8;
  localparam int FRAC       = 8;
  localparam int OUT_SHIFT  = 40 - FRAC;
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE     = 20;
  localparam int PHASES     = 10;
  localparam int PHASE_ITEMS = 125;
  localparam longint unsigned TERM_CAP  = (64'd1 << 47) - 1;
  localparam longint unsigned DELTA_CAP = 64'd1 << 26;
  localparam longint POS_MAX = 8388607;
  localparam longint POS_MIN = -8388608;

  typedef enum logic { ROW_CFG, ROW_ITEM } row_kind_t;

  typedef struct {
    logic                    mode;
    logic [2:0]              idx;
    logic signed [POS_W-1:0] bx, by;
    logic [MASS_W-1:0]       bm;
    logic signed [POS_W-1:0] px, py, ox, oy;
  } particle_item_t;

  // Field order matches m_axis_tdata from the highest bit down.
  typedef struct packed {
    logic signed [POS_W-1:0] prior_y;
    logic signed [POS_W-1:0] prior_x;
    logic signed [POS_W-1:0] next_y;
    logic signed [POS_W-1:0] next_x;
  } step_out_t;

  typedef struct {
    row_kind_t                kind;
    logic [CFG_IDX_W-1:0]     reg_idx;
    logic [31:0]              reg_val;
    particle_item_t           it;
    bit                       has_exp;
    step_out_t                exp_out;
  } stim_row_t;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [167:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [95:0]  m_axis_tdata;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  // Model copy of the body table and registers
  logic signed [POS_W-1:0] tbl_x [BODIES];
  logic signed [POS_W-1:0] tbl_y [BODIES];
  logic [MASS_W-1:0]       tbl_m [BODIES];
  logic [ACT_W-1:0]        m_active;
  logic [GAIN_W-1:0]       m_gain;
  logic [MSQ_W-1:0]        m_min_sq;

  step_out_t pending_steps[$];
  stim_row_t directed[$];
  int send_gap_pct, recv_stall_pct;
  int n_loads, n_steps, n_results, n_cfg, n_errors, idle_cycles;

  gravity_verlet_step dut (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #5 clk = ~clk;

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // floor(num * 2^sh / den), capped at the term limit
  function automatic longint unsigned frac_quot(longint unsigned num,
                                                longint unsigned den, int sh);
    longint unsigned q, rem;
    q = num / den;
    rem = num % den;
    if (q > TERM_CAP) return TERM_CAP;
    for (int i = 0; i < sh; i++) begin
      rem <<= 1;
      q <<= 1;
      if (rem >= den) begin
        rem -= den;
        q |= 1;
      end
      if (q > TERM_CAP) return TERM_CAP;
    end
    return q;
  endfunction

  function automatic longint scaled_pull(longint acc);
    longint unsigned mag, d;
    logic [95:0] prod;
    mag = acc < 0 ? -acc : acc;
    prod = 96'(mag) * 96'(m_gain);
    d = 64'(prod >> OUT_SHIFT);
    if (prod >> OUT_SHIFT > DELTA_CAP) d = DELTA_CAP;
    return acc < 0 ? -longint'(d) : longint'(d);
  endfunction

  function automatic longint clamp_pos(longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  // Sum the pull of the active bodies and form the Verlet update
  function automatic step_out_t verlet_next(particle_item_t it);
    longint ax, ay, dx, dy;
    longint unsigned adx, ady, dsq, lim, r, ux, uy, tx, ty;
    int cnt;
    step_out_t o;
    ax = 0;
    ay = 0;
    cnt = int'(m_active) > BODIES ? BODIES : int'(m_active);
    lim = longint'(m_min_sq) << (2 * FRAC);
    for (int k = 0; k < cnt; k++) begin
      dx = longint'(tbl_x[k]) - longint'(it.px);
      dy = longint'(tbl_y[k]) - longint'(it.py);
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      dsq = adx * adx + ady * ady;
      if (dsq > lim) begin
        r = root_floor(dsq);
        ux = frac_quot(longint'(tbl_m[k]) * adx, r, 16);
        uy = frac_quot(longint'(tbl_m[k]) * ady, r, 16);
        tx = frac_quot(ux, dsq, 2 * FRAC);
        ty = frac_quot(uy, dsq, 2 * FRAC);
        ax += dx < 0 ? -longint'(tx) : longint'(tx);
        ay += dy < 0 ? -longint'(ty) : longint'(ty);
      end
    end
    o.next_x  = POS_W'(clamp_pos(2 * longint'(it.px) - longint'(it.ox) + scaled_pull(ax)));
    o.next_y  = POS_W'(clamp_pos(2 * longint'(it.py) - longint'(it.oy) + scaled_pull(ay)));
    o.prior_x = it.px;
    o.prior_y = it.py;
    return o;
  endfunction

  function automatic particle_item_t load_item(int idx, int x, int y, int m);
    particle_item_t it;
    it = '{default: '0};
    it.mode = MODE_LOAD;
    it.idx = 3'(idx);
    it.bx = POS_W'(x);
    it.by = POS_W'(y);
    it.bm = MASS_W'(m);
    return it;
  endfunction

  function automatic particle_item_t step_item(int px, int py, int ox, int oy);
    particle_item_t it;
    it = '{default: '0};
    it.mode = ~MODE_LOAD;
    it.px = POS_W'(px);
    it.py = POS_W'(py);
    it.ox = POS_W'(ox);
    it.oy = POS_W'(oy);
    return it;
  endfunction

  function automatic void add_row(particle_item_t it);
    stim_row_t r;
    r = '{kind: ROW_ITEM, reg_idx: '0, reg_val: '0, it: it, has_exp: 0, exp_out: '0};
    directed.push_back(r);
  endfunction

  function automatic void add_known(particle_item_t it, int nx, int ny);
    stim_row_t r;
    r = '{kind: ROW_ITEM, reg_idx: '0, reg_val: '0, it: it, has_exp: 1, exp_out: '0};
    r.exp_out.next_x = POS_W'(nx);
    r.exp_out.next_y = POS_W'(ny);
    r.exp_out.prior_x = it.px;
    r.exp_out.prior_y = it.py;
    directed.push_back(r);
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    stim_row_t r;
    r = '{kind: ROW_CFG, reg_idx: idx, reg_val: val, it: '{default: '0},
          has_exp: 0, exp_out: '0};
    directed.push_back(r);
  endfunction

  // Hold off the sender until the block has drained
  task automatic drain_block();
    s_axis_tvalid = 0;
    while (pending_steps.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_ACTIVE: m_active = val[ACT_W-1:0];
      CFG_GAIN:   m_gain = val;
      CFG_MIN_SQ: m_min_sq = val[MSQ_W-1:0];
      default: ;
    endcase
    n_cfg++;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic send_item(particle_item_t it, bit has_exp, step_out_t exp_out);
    if ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid = 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    s_axis_tvalid = 1;
    s_axis_tuser = it.mode;
    s_axis_tdata = {3'b000, it.oy, it.ox, it.py, it.px, it.bm, it.by, it.bx, it.idx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (it.mode == MODE_LOAD) begin
      tbl_x[it.idx] = it.bx;
      tbl_y[it.idx] = it.by;
      tbl_m[it.idx] = it.bm;
      n_loads++;
    end else begin
      pending_steps.push_back(has_exp ? exp_out : verlet_next(it));
      n_steps++;
    end
    @(negedge clk);
  endtask

  // Random item: mostly particles close to a loaded body, some anywhere
  function automatic particle_item_t random_item();
    particle_item_t it;
    int k, span;
    it = '{default: '0};
    if ($urandom_range(99) < 15) begin
      it.mode = MODE_LOAD;
      it.idx = 3'($urandom);
      if ($urandom_range(3) == 0) begin
        it.bx = POS_W'($urandom);
        it.by = POS_W'($urandom);
      end else begin
        it.bx = POS_W'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
        it.by = POS_W'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      end
      it.bm = MASS_W'($urandom_range(1) ? $urandom : $urandom_range(1, 5000));
    end else begin
      it.mode = ~MODE_LOAD;
      k = $urandom_range(BODIES - 1);
      span = 1 << $urandom_range(4, 20);
      if ($urandom_range(9) < 7) begin
        it.px = POS_W'(tbl_x[k] + $signed($urandom_range(0, 2 * span)) - span);
        it.py = POS_W'(tbl_y[k] + $signed($urandom_range(0, 2 * span)) - span);
        it.ox = POS_W'(it.px + $signed($urandom_range(0, 512)) - 256);
        it.oy = POS_W'(it.py + $signed($urandom_range(0, 512)) - 256);
      end else begin
        it.px = POS_W'($urandom);
        it.py = POS_W'($urandom);
        it.ox = POS_W'($urandom);
        it.oy = POS_W'($urandom);
      end
      it.idx = 3'($urandom);
      it.bx = POS_W'($urandom);
      it.by = POS_W'($urandom);
      it.bm = MASS_W'($urandom);
    end
    return it;
  endfunction

  // Receiver stalls at the current rate
  always @(negedge clk) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    step_out_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      n_results++;
      if (pending_steps.size() == 0) begin
        $display("%0t: result with nothing expected: got %h", $realtime, got);
        n_errors++;
      end else begin
        want = pending_steps.pop_front();
        if (got.next_x !== want.next_x) begin
          $display("%0t: next_x expected %h got %h", $realtime, want.next_x, got.next_x);
          n_errors++;
        end
        if (got.next_y !== want.next_y) begin
          $display("%0t: next_y expected %h got %h", $realtime, want.next_y, got.next_y);
          n_errors++;
        end
        if (got.prior_x !== want.prior_x) begin
          $display("%0t: prior_x expected %h got %h", $realtime, want.prior_x, got.prior_x);
          n_errors++;
        end
        if (got.prior_y !== want.prior_y) begin
          $display("%0t: prior_y expected %h got %h", $realtime, want.prior_y, got.prior_y);
          n_errors++;
        end
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int total;
    logic [31:0] gain_pick [4];
    logic [15:0] msq_pick [4];
    n_loads = 0; n_steps = 0; n_cfg = 0;
    send_gap_pct = 12;
    recv_stall_pct = 57;
    m_active = 0;
    m_gain = 32'd16777216;
    m_min_sq = 16'd25;
    gain_pick = '{32'd0, 32'hFFFF_FFFF, 32'd16777216, 32'd1 << 20};
    msq_pick = '{16'd0, 16'hFFFF, 16'd25, 16'd4};

    // With no bodies active the step is plain 2*pos - old, saturated
    add_known(step_item(100, -200, 50, -100), 150, -300);
    add_known(step_item(POS_MAX, POS_MIN, POS_MIN, POS_MAX), POS_MAX, POS_MIN);
    add_known(step_item(0, 0, 0, 0), 0, 0);
    // Fill every slot, extremes of position and mass among them
    add_row(load_item(0, 256, 0, 262143));
    add_row(load_item(1, -5120, 2560, 1000));
    add_row(load_item(2, POS_MAX, POS_MAX, 262143));
    add_row(load_item(3, 0, -7680, 1));
    add_row(load_item(4, 12800, 12800, 50000));
    add_row(load_item(5, -2560, -2560, 300));
    add_row(load_item(6, 1280, -1280, 7000));
    add_row(load_item(7, POS_MIN, POS_MIN, 0));
    add_cfg(CFG_ACTIVE, 8);
    add_row(step_item(1000, 1000, 990, 1010));
    // Body one fraction away with no threshold: term saturates
    add_cfg(CFG_MIN_SQ, 0);
    add_row(step_item(257, 0, 257, 0));
    // Largest gain drives the delta into its cap
    add_cfg(CFG_GAIN, 32'hFFFF_FFFF);
    add_row(step_item(257, 1, 250, 3));
    add_row(step_item(-100000, 200000, -100000, 200000));
    // Active count above the table size clamps to the table
    add_cfg(CFG_ACTIVE, 15);
    add_cfg(CFG_GAIN, 32'd16777216);
    add_row(step_item(-5000, 2500, -5010, 2490));
    // Widest threshold skips nearby bodies
    add_cfg(CFG_MIN_SQ, 16'hFFFF);
    add_row(step_item(300, 10, 300, 10));
    add_cfg(CFG_GAIN, 32'd0);
    add_row(step_item(3000, -3000, 2000, -2000));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        drain_block();
        write_reg(directed[i].reg_idx, directed[i].reg_val);
      end else begin
        send_item(directed[i].it, directed[i].has_exp, directed[i].exp_out);
      end
    end

    // Random phases, each under fresh register settings
    total = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_block();
      write_reg(CFG_ACTIVE, ph == 0 ? 8 : $urandom_range(15));
      write_reg(CFG_GAIN, $urandom_range(2) == 0 ? $urandom : gain_pick[$urandom_range(3)]);
      write_reg(CFG_MIN_SQ, $urandom_range(3) == 0 ? $urandom_range(400)
                                                   : msq_pick[$urandom_range(3)]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (total < PHASES * PHASE_ITEMS / 3) begin
          send_gap_pct = 12;
          recv_stall_pct = 57;
        end else if (total < 2 * PHASES * PHASE_ITEMS / 3) begin
          send_gap_pct = 57;
          recv_stall_pct = 12;
        end else begin
          send_gap_pct = 0;
          recv_stall_pct = 0;
        end
        send_item(random_item(), 0, '0);
        total++;
      end
    end

    drain_block();
    repeat (100) @(posedge clk);
    $display("Covered %0d body loads, %0d particle steps and %0d register writes;",
             n_loads, n_steps, n_cfg);
    $display("%0d results checked, %0d mismatches.", n_results, n_errors);
    if (n_errors == 0 && pending_steps.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/gvs_pkg.sv
rtl/gvs_cell.sv
rtl/gvs_sqrt.sv
rtl/gvs_div.sv
rtl/gravity_verlet_step.sv
sim/gravity_verlet_step_tb.sv
